// File: src/usbsrd_pkg.sv
// Shared types and constants for the USB setup request decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package usbsrd_pkg;

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } in_t;

  // Result as it leaves on the output channel.
  typedef struct packed {
    logic        stall_res;
    logic [2:0]  response_kind;
    logic [3:0]  string_number;
    logic [7:0]  reply_length;
    logic        notify_after;
    logic        dfu_detach;
    logic [6:0]  device_address;
    logic        mgmt_running;
    logic        network_running;
  } out_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_STATUS     = 3'd1,
    KIND_DFU_STATUS = 3'd2,
    KIND_DEVICE     = 3'd3,
    KIND_CONFIG     = 3'd4,
    KIND_QUALIFIER  = 3'd5,
    KIND_STRING     = 3'd6
  } kind_t;

  // Opcode values of the input item.
  localparam logic OPC_SETUP     = 1'b0;
  localparam logic OPC_BUS_RESET = 1'b1;

  // Request keys: {bRequest, bmRequestType}.
  localparam logic [15:0] KEY_DFU_DETACH    = 16'h0021;
  localparam logic [15:0] KEY_GET_STATUS    = 16'h0080;
  localparam logic [15:0] KEY_DFU_GETSTATUS = 16'h03a1;
  localparam logic [15:0] KEY_GET_DESC      = 16'h0680;
  localparam logic [15:0] KEY_SET_ADDRESS   = 16'h0500;
  localparam logic [15:0] KEY_SET_CONFIG    = 16'h0900;
  localparam logic [15:0] KEY_SET_INTERFACE = 16'h0b01;
  localparam logic [15:0] KEY_SET_FILTER    = 16'h4321;

  // Descriptor types in the high byte of wValue.
  localparam logic [7:0] DESC_DEVICE    = 8'd1;
  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_STRING    = 8'd3;
  localparam logic [7:0] DESC_QUALIFIER = 8'd6;

  // Interface numbers seen by set interface.
  localparam logic [15:0] IFACE_MGMT  = 16'd0;
  localparam logic [15:0] IFACE_DATA  = 16'd1;
  localparam logic [15:0] IFACE_DFU   = 16'd4;

  localparam logic [7:0] LEN_STATUS     = 8'd2;
  localparam logic [7:0] LEN_DFU_STATUS = 8'd6;
  localparam logic [7:0] LEN_DEVICE     = 8'd18;
  localparam logic [7:0] LEN_CONFIG     = 8'd142;
  localparam logic [7:0] LEN_QUALIFIER  = 8'd10;

  localparam int unsigned STRING_COUNT = 11;
  localparam logic [7:0] STRING_LEN [STRING_COUNT] = '{
    8'd4, 8'd12, 8'd14, 8'd10, 8'd26, 8'd40, 8'd28, 8'd36, 8'd14, 8'd20, 8'd8
  };

  // State action that the back end applies when it retires a request.
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_BUS_RESET  = 3'd1,
    ACT_SET_ADDR   = 3'd2,
    ACT_SET_CONFIG = 3'd3,
    ACT_NET_START  = 3'd4,
    ACT_NET_STOP   = 3'd5
  } act_t;

  // Classified request passed from the front end through the queue.
  typedef struct packed {
    act_t        act;
    logic        stall;
    kind_t       kind;
    logic [3:0]  string_number;
    logic [7:0]  reply_length;
    logic        notify;
    logic        dfu;
    logic [6:0]  address;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/usb_setup_request_decoder.sv
// Top level of the USB setup request decoder: front end, command queue, back end.
// Depends on usbsrd_pkg, usbsrd_front, usbsrd_queue and usbsrd_back.
//
// The block takes one request per clock while in_ready is high: a setup
// packet or a bus reset goes in, and exactly one result comes out for each,
// in order. A request is decoded as it is accepted and written into a small
// queue; the back end retires one queued request per cycle, while the output
// register is empty or being taken, into the output register, updating the
// device address and the management and network run state as it does. A
// result passes through the queue and then the output register, and is offered
// on out_valid once it is in the output register. While the output is stalled,
// the queue absorbs up to QUEUE_DEPTH further requests before in_ready drops.
`default_nettype none

module usb_setup_request_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  usbsrd_pkg::in_t    in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output usbsrd_pkg::out_t   out_data
);

  usbsrd_pkg::cmd_t  front_cmd;
  usbsrd_pkg::cmd_t  queue_cmd;
  logic              queue_full;
  logic              queue_empty;
  logic              queue_pop;

  usbsrd_front u_front (
    .req_i (in_data),
    .cmd_o (front_cmd)
  );

  usbsrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_valid),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_cmd)
  );

  usbsrd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty_i (queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  assign in_ready = !queue_full;

endmodule

`default_nettype wire

// File: src/usbsrd_front.sv
// Front end: classifies one setup request or bus reset into a command.
// Depends on usbsrd_pkg; purely combinational, feeds the command queue.
`default_nettype none

module usbsrd_front (
  input  usbsrd_pkg::in_t  req_i,
  output usbsrd_pkg::cmd_t cmd_o
);

  logic [15:0]         key;
  logic [7:0]          dtype;
  logic [7:0]          didx;
  logic [7:0]          natural_len;
  usbsrd_pkg::cmd_t    cmd;

  assign key   = {req_i.request_code, req_i.request_type};
  assign dtype = req_i.request_value[15:8];
  assign didx  = req_i.request_value[7:0];

  always_comb begin
    cmd             = '0;
    cmd.act         = usbsrd_pkg::ACT_NONE;
    cmd.kind        = usbsrd_pkg::KIND_NONE;
    natural_len     = '0;
    cmd.address     = req_i.request_value[6:0];

    if (req_i.opcode == usbsrd_pkg::OPC_BUS_RESET) begin
      cmd.act = usbsrd_pkg::ACT_BUS_RESET;
    end else begin
      unique case (key)
        usbsrd_pkg::KEY_DFU_DETACH: begin
          cmd.dfu = 1'b1;
        end
        usbsrd_pkg::KEY_GET_STATUS: begin
          cmd.kind    = usbsrd_pkg::KIND_STATUS;
          natural_len = usbsrd_pkg::LEN_STATUS;
        end
        usbsrd_pkg::KEY_DFU_GETSTATUS: begin
          cmd.kind    = usbsrd_pkg::KIND_DFU_STATUS;
          natural_len = usbsrd_pkg::LEN_DFU_STATUS;
        end
        usbsrd_pkg::KEY_GET_DESC: begin
          if (dtype == usbsrd_pkg::DESC_DEVICE) begin
            cmd.kind    = usbsrd_pkg::KIND_DEVICE;
            natural_len = usbsrd_pkg::LEN_DEVICE;
          end else if (dtype == usbsrd_pkg::DESC_CONFIG) begin
            cmd.kind    = usbsrd_pkg::KIND_CONFIG;
            natural_len = usbsrd_pkg::LEN_CONFIG;
          end else if (dtype == usbsrd_pkg::DESC_QUALIFIER) begin
            cmd.kind    = usbsrd_pkg::KIND_QUALIFIER;
            natural_len = usbsrd_pkg::LEN_QUALIFIER;
          end else if (dtype == usbsrd_pkg::DESC_STRING &&
                       didx < 8'(usbsrd_pkg::STRING_COUNT)) begin
            cmd.kind          = usbsrd_pkg::KIND_STRING;
            cmd.string_number = didx[3:0];
            natural_len       = usbsrd_pkg::STRING_LEN[didx[3:0]];
          end else begin
            cmd.stall = 1'b1;
          end
        end
        usbsrd_pkg::KEY_SET_ADDRESS: begin
          cmd.act = usbsrd_pkg::ACT_SET_ADDR;
        end
        usbsrd_pkg::KEY_SET_CONFIG: begin
          cmd.act    = usbsrd_pkg::ACT_SET_CONFIG;
          cmd.notify = 1'b1;
        end
        usbsrd_pkg::KEY_SET_INTERFACE: begin
          if (req_i.request_index == usbsrd_pkg::IFACE_DATA) begin
            if (req_i.request_value != 16'd0) begin
              cmd.act    = usbsrd_pkg::ACT_NET_START;
              cmd.notify = 1'b1;
            end else begin
              cmd.act = usbsrd_pkg::ACT_NET_STOP;
            end
          end else if (req_i.request_index != usbsrd_pkg::IFACE_MGMT &&
                       req_i.request_index != usbsrd_pkg::IFACE_DFU) begin
            cmd.stall = 1'b1;
          end
        end
        usbsrd_pkg::KEY_SET_FILTER: begin
          cmd.act = usbsrd_pkg::ACT_NONE;
        end
        default: begin
          cmd.stall = 1'b1;
        end
      endcase
    end

    // A stalled request leaves no trace other than the stall itself.
    if (cmd.stall) begin
      cmd.act           = usbsrd_pkg::ACT_NONE;
      cmd.kind          = usbsrd_pkg::KIND_NONE;
      cmd.string_number = '0;
      cmd.notify        = 1'b0;
      cmd.dfu           = 1'b0;
      natural_len       = '0;
    end

    if (req_i.request_length < {8'd0, natural_len}) begin
      cmd.reply_length = req_i.request_length[7:0];
    end else begin
      cmd.reply_length = natural_len;
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

// File: src/usbsrd_queue.sv
// Short command queue between the decode front end and the execute back end.
// Depends on usbsrd_pkg for the command type; DEPTH from 2 to 16.
`default_nettype none

module usbsrd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  usbsrd_pkg::cmd_t      push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output usbsrd_pkg::cmd_t      pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  usbsrd_pkg::cmd_t  entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_r == CNT_W'(DEPTH));
  assign empty_o    = (count_r == '0);
  assign pop_data_o = entry_r[rd_ptr_r];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/usbsrd_back.sv
// Back end: retires commands in order, updates address and run state,
// and holds the result in the output register. Depends on usbsrd_pkg.
`default_nettype none

module usbsrd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty_i,
  input  usbsrd_pkg::cmd_t   cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output usbsrd_pkg::out_t   out_data_o
);

  logic [6:0]        address_r, address_nxt;
  logic              mgmt_on_r, mgmt_on_nxt;
  logic              net_on_r,  net_on_nxt;
  logic              out_valid_r, out_valid_nxt;
  usbsrd_pkg::out_t  out_data_r, out_data_nxt;

  // The output register refills in the same cycle it is taken.
  assign cmd_pop_o = !cmd_empty_i && (!out_valid_r || out_ready_i);

  always_comb begin
    address_nxt   = address_r;
    mgmt_on_nxt   = mgmt_on_r;
    net_on_nxt    = net_on_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    out_data_nxt  = out_data_r;

    if (cmd_pop_o) begin
      unique case (cmd_i.act)
        usbsrd_pkg::ACT_BUS_RESET: begin
          address_nxt = '0;
          mgmt_on_nxt = 1'b0;
          net_on_nxt  = 1'b0;
        end
        usbsrd_pkg::ACT_SET_ADDR: begin
          address_nxt = cmd_i.address;
          if (cmd_i.address == '0) begin
            mgmt_on_nxt = 1'b0;
            net_on_nxt  = 1'b0;
          end
        end
        usbsrd_pkg::ACT_SET_CONFIG: begin
          mgmt_on_nxt = 1'b1;
          net_on_nxt  = 1'b0;
        end
        usbsrd_pkg::ACT_NET_START: begin
          net_on_nxt = 1'b1;
        end
        usbsrd_pkg::ACT_NET_STOP: begin
          net_on_nxt = 1'b0;
        end
        default: begin
        end
      endcase

      out_valid_nxt                = 1'b1;
      out_data_nxt.stall_res       = cmd_i.stall;
      out_data_nxt.response_kind   = cmd_i.kind;
      out_data_nxt.string_number   = cmd_i.string_number;
      out_data_nxt.reply_length    = cmd_i.reply_length;
      out_data_nxt.notify_after    = cmd_i.notify;
      out_data_nxt.dfu_detach      = cmd_i.dfu;
      out_data_nxt.device_address  = address_nxt;
      out_data_nxt.mgmt_running    = mgmt_on_nxt;
      out_data_nxt.network_running = net_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r   <= '0;
      mgmt_on_r   <= 1'b0;
      net_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      address_r   <= address_nxt;
      mgmt_on_r   <= mgmt_on_nxt;
      net_on_r    <= net_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

`default_nettype wire

// File: src/usbsrd_checker.sv
// Port-level checks for the USB setup request decoder, bound to the top level.
// Depends on usbsrd_pkg and usb_setup_request_decoder.
`default_nettype none

module usbsrd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire usbsrd_pkg::out_t  out_data
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // A stalled request carries no reply.
  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stall_res |->
      out_data.response_kind == usbsrd_pkg::KIND_NONE &&
      out_data.reply_length == 8'd0 && !out_data.notify_after &&
      !out_data.dfu_detach)
    else $error("stall carries reply fields");

  // String numbers appear only with string replies.
  a_string_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.response_kind != usbsrd_pkg::KIND_STRING |->
      out_data.string_number == 4'd0)
    else $error("string number outside a string reply");

endmodule

bind usb_setup_request_decoder usbsrd_checker u_usbsrd_checker (.*);

`default_nettype wire

// File: sim/usb_setup_request_decoder_tb.sv
// Self-checking testbench for usb_setup_request_decoder: directed and random setup
// requests and bus resets, each reply predicted in order and compared field by field.
// Depends on usbsrd_pkg and the usb_setup_request_decoder top level.
`timescale 1ns / 1ps

module usb_setup_request_decoder_tb;

  localparam int unsigned RANDOM_REQUESTS = 1300;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned SETTLE_CYCLES = 20;

  localparam logic [7:0] STATUS_BYTES = 8'd2;
  localparam logic [7:0] DFU_STATUS_BYTES = 8'd6;
  localparam logic [7:0] DEVICE_DESC_BYTES = 8'd18;
  localparam logic [7:0] CONFIG_DESC_BYTES = 8'd142;
  localparam logic [7:0] QUALIFIER_DESC_BYTES = 8'd10;
  localparam int unsigned NUM_STRINGS = 11;
  localparam logic [7:0] STRING_REPLY_LEN [NUM_STRINGS] = '{
    8'd4, 8'd12, 8'd14, 8'd10, 8'd26, 8'd40, 8'd28, 8'd36, 8'd14, 8'd20, 8'd8
  };
  localparam logic [15:0] KNOWN_KEYS [8] = '{
    usbsrd_pkg::KEY_DFU_DETACH, usbsrd_pkg::KEY_GET_STATUS,
    usbsrd_pkg::KEY_DFU_GETSTATUS, usbsrd_pkg::KEY_GET_DESC,
    usbsrd_pkg::KEY_SET_ADDRESS, usbsrd_pkg::KEY_SET_CONFIG,
    usbsrd_pkg::KEY_SET_INTERFACE, usbsrd_pkg::KEY_SET_FILTER
  };

  typedef struct {
    usbsrd_pkg::in_t req;
    bit              drain_first;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  usbsrd_pkg::in_t  in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  usbsrd_pkg::out_t out_data;

  pending_t         setup_queue[$];
  usbsrd_pkg::out_t expected_replies[$];

  // Device state as the predictor sees it.
  logic [6:0] model_addr = '0;
  logic       model_mgmt = 1'b0;
  logic       model_net = 1'b0;

  int unsigned requests_sent = 0;
  int unsigned replies_checked = 0;
  int unsigned fail_count = 0;
  int unsigned stall_count = 0;
  int unsigned bus_resets = 0;
  int unsigned string_replies = 0;
  int unsigned long_holds = 0;
  int unsigned drain_pauses = 0;
  int unsigned cycle_count = 0;

  int unsigned src_gap = 0;
  int unsigned src_run = 0;
  bit          src_quiet = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned sink_run = 0;
  bit          sink_quiet = 1'b0;
  bit          hold_active = 1'b0;

  usb_setup_request_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Idle time runs in stretches; some stretches have no idling at all.
  task automatic pick_pause(inout int unsigned run_left, inout bit quiet,
                            output int unsigned pause);
    if (run_left == 0) begin
      run_left = $urandom_range(15, 60);
      quiet = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    pause = quiet ? 0 : $urandom_range(0, 13);
  endtask

  function automatic usbsrd_pkg::out_t decode_request(usbsrd_pkg::in_t req);
    usbsrd_pkg::out_t  rep;
    logic [15:0]       key;
    logic              stall;
    usbsrd_pkg::kind_t kind;
    logic [3:0]        str_idx;
    logic [7:0]        full_len;
    logic              notify;
    logic              detach;
    key = {req.request_code, req.request_type};
    stall = 1'b0;
    kind = usbsrd_pkg::KIND_NONE;
    str_idx = '0;
    full_len = '0;
    notify = 1'b0;
    detach = 1'b0;
    if (req.opcode == usbsrd_pkg::OPC_BUS_RESET) begin
      model_addr = '0;
      model_mgmt = 1'b0;
      model_net = 1'b0;
    end else begin
      case (key)
        usbsrd_pkg::KEY_DFU_DETACH: detach = 1'b1;
        usbsrd_pkg::KEY_GET_STATUS: begin
          kind = usbsrd_pkg::KIND_STATUS;
          full_len = STATUS_BYTES;
        end
        usbsrd_pkg::KEY_DFU_GETSTATUS: begin
          kind = usbsrd_pkg::KIND_DFU_STATUS;
          full_len = DFU_STATUS_BYTES;
        end
        usbsrd_pkg::KEY_GET_DESC: begin
          if (req.request_value[15:8] == usbsrd_pkg::DESC_DEVICE) begin
            kind = usbsrd_pkg::KIND_DEVICE;
            full_len = DEVICE_DESC_BYTES;
          end else if (req.request_value[15:8] == usbsrd_pkg::DESC_CONFIG) begin
            kind = usbsrd_pkg::KIND_CONFIG;
            full_len = CONFIG_DESC_BYTES;
          end else if (req.request_value[15:8] == usbsrd_pkg::DESC_QUALIFIER) begin
            kind = usbsrd_pkg::KIND_QUALIFIER;
            full_len = QUALIFIER_DESC_BYTES;
          end else if (req.request_value[15:8] == usbsrd_pkg::DESC_STRING &&
                       req.request_value[7:0] < NUM_STRINGS) begin
            kind = usbsrd_pkg::KIND_STRING;
            str_idx = req.request_value[3:0];
            full_len = STRING_REPLY_LEN[req.request_value[3:0]];
          end else begin
            stall = 1'b1;
          end
        end
        usbsrd_pkg::KEY_SET_ADDRESS: begin
          model_addr = req.request_value[6:0];
          if (model_addr == '0) begin
            model_net = 1'b0;
            model_mgmt = 1'b0;
          end
        end
        usbsrd_pkg::KEY_SET_CONFIG: begin
          model_net = 1'b0;
          model_mgmt = 1'b1;
          notify = 1'b1;
        end
        usbsrd_pkg::KEY_SET_INTERFACE: begin
          if (req.request_index == usbsrd_pkg::IFACE_DATA) begin
            if (req.request_value != '0) begin
              model_net = 1'b1;
              notify = 1'b1;
            end else begin
              model_net = 1'b0;
            end
          end else if (req.request_index != usbsrd_pkg::IFACE_MGMT &&
                       req.request_index != usbsrd_pkg::IFACE_DFU) begin
            stall = 1'b1;
          end
        end
        usbsrd_pkg::KEY_SET_FILTER: ;
        default: stall = 1'b1;
      endcase
    end
    // Every stalling path leaves the reply fields at zero and the state untouched.
    rep.stall_res = stall;
    rep.response_kind = kind;
    rep.string_number = str_idx;
    rep.reply_length = ({8'd0, full_len} > req.request_length) ? req.request_length[7:0]
                                                               : full_len;
    rep.notify_after = notify;
    rep.dfu_detach = detach;
    rep.device_address = model_addr;
    rep.mgmt_running = model_mgmt;
    rep.network_running = model_net;
    return rep;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_reply(usbsrd_pkg::out_t want, usbsrd_pkg::out_t got);
    compare_field("stall_res", want.stall_res, got.stall_res);
    compare_field("response_kind", want.response_kind, got.response_kind);
    compare_field("string_number", want.string_number, got.string_number);
    compare_field("reply_length", want.reply_length, got.reply_length);
    compare_field("notify_after", want.notify_after, got.notify_after);
    compare_field("dfu_detach", want.dfu_detach, got.dfu_detach);
    compare_field("device_address", want.device_address, got.device_address);
    compare_field("mgmt_running", want.mgmt_running, got.mgmt_running);
    compare_field("network_running", want.network_running, got.network_running);
  endtask

  function automatic usbsrd_pkg::in_t setup_req(logic [15:0] key, logic [15:0] value,
                                                logic [15:0] index, logic [15:0] length);
    usbsrd_pkg::in_t r;
    r.opcode = usbsrd_pkg::OPC_SETUP;
    r.request_type = key[7:0];
    r.request_code = key[15:8];
    r.request_value = value;
    r.request_index = index;
    r.request_length = length;
    return r;
  endfunction

  task automatic enqueue(usbsrd_pkg::in_t req, bit drain_first);
    pending_t p;
    p.req = req;
    p.drain_first = drain_first;
    setup_queue.push_back(p);
  endtask

  // Mostly well-formed requests with random content; the rest are near misses,
  // random keys and bus resets.
  function automatic usbsrd_pkg::in_t random_request();
    usbsrd_pkg::in_t r;
    int unsigned pick;
    logic [15:0] key;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    pick = $urandom_range(0, 99);
    value = 16'($urandom);
    index = 16'($urandom);
    case ($urandom_range(0, 3))
      0: length = 16'd0;
      1: length = 16'($urandom);
      default: length = 16'($urandom_range(0, 160));
    endcase
    key = KNOWN_KEYS[$urandom_range(0, 7)];
    if (key == usbsrd_pkg::KEY_GET_DESC) begin
      case ($urandom_range(0, 5))
        0: value[15:8] = usbsrd_pkg::DESC_DEVICE;
        1: value[15:8] = usbsrd_pkg::DESC_CONFIG;
        2: value[15:8] = usbsrd_pkg::DESC_QUALIFIER;
        3, 4: begin
          value[15:8] = usbsrd_pkg::DESC_STRING;
          if ($urandom_range(0, 4) != 0) value[7:0] = 8'($urandom_range(0, 12));
        end
        default: ;
      endcase
    end else if (key == usbsrd_pkg::KEY_SET_INTERFACE) begin
      case ($urandom_range(0, 4))
        0: index = usbsrd_pkg::IFACE_MGMT;
        1, 2: index = usbsrd_pkg::IFACE_DATA;
        3: index = usbsrd_pkg::IFACE_DFU;
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) value = 16'd0;
    end else if (key == usbsrd_pkg::KEY_SET_ADDRESS && $urandom_range(0, 7) == 0) begin
      value[6:0] = 7'd0;
    end
    if (pick < 5) begin
      key = {key[7:0], key[15:8]};
    end else if (pick < 10) begin
      key = key ^ 16'(1 << $urandom_range(0, 15));
    end else if (pick < 15) begin
      key = 16'($urandom);
    end
    r = setup_req(key, value, index, length);
    if (pick >= 95) r.opcode = usbsrd_pkg::OPC_BUS_RESET;
    return r;
  endfunction

  // Request driver: an item marked drain_first waits until every reply is in.
  always @(posedge clk) begin : drive_requests
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) requests_sent++;
      if (src_gap != 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (setup_queue.size() != 0 &&
                   (!setup_queue[0].drain_first || requests_sent == replies_checked)) begin
        nxt = setup_queue.pop_front();
        if (nxt.drain_first) drain_pauses++;
        in_data <= nxt.req;
        in_valid <= 1'b1;
        pick_pause(src_run, src_quiet, src_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long stretches with the output held off while requests keep coming.
  initial begin : long_hold
    wait (replies_checked >= 300);
    @(posedge clk);
    hold_active <= 1'b1;
    long_holds++;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active <= 1'b0;
    wait (replies_checked >= 1000);
    @(posedge clk);
    hold_active <= 1'b1;
    long_holds++;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Reply monitor: predicts each accepted request and checks replies in order.
  always @(posedge clk) begin : check_replies
    usbsrd_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.opcode == usbsrd_pkg::OPC_BUS_RESET) bus_resets++;
        expected_replies.push_back(decode_request(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (want.stall_res) stall_count++;
          if (want.response_kind == usbsrd_pkg::KIND_STRING) string_replies++;
          check_reply(want, out_data);
        end
        replies_checked++;
        pick_pause(sink_run, sink_quiet, sink_wait);
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    usbsrd_pkg::in_t r;
    r.opcode = usbsrd_pkg::OPC_BUS_RESET;
    r.request_type = 8'hff;
    r.request_code = 8'hff;
    r.request_value = 16'hffff;
    r.request_index = 16'hffff;
    r.request_length = 16'hffff;
    enqueue(r, 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_STATUS, 16'h0000, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_STATUS, 16'hffff, 16'hffff, 16'd1), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_STATUS, 16'h0000, 16'h0000, 16'hffff), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_DFU_GETSTATUS, 16'h0000, 16'h0000, 16'd5), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_DFU_GETSTATUS, 16'h0000, 16'h0000, 16'd6), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_DEVICE, 8'h00},
                      16'h0000, 16'hffff), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_CONFIG, 8'h00},
                      16'h0000, 16'd141), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_CONFIG, 8'h00},
                      16'h0000, 16'd255), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_QUALIFIER, 8'h00},
                      16'h0000, 16'd9), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_STRING, 8'd0},
                      16'h0409, 16'd100), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_STRING, 8'd10},
                      16'h0409, 16'hffff), 1'b0);
    // String index just past the table stalls, as does an unknown descriptor type.
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, {usbsrd_pkg::DESC_STRING, 8'd11},
                      16'h0409, 16'hffff), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_GET_DESC, 16'hffff, 16'h0000, 16'hffff), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_ADDRESS, 16'hffff, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_CONFIG, 16'h0001, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'h0001, usbsrd_pkg::IFACE_DATA,
                      16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'hffff, usbsrd_pkg::IFACE_DFU,
                      16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'h0000, usbsrd_pkg::IFACE_MGMT,
                      16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'h0001, 16'd2, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'h0000, usbsrd_pkg::IFACE_DATA,
                      16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_INTERFACE, 16'h8000, usbsrd_pkg::IFACE_DATA,
                      16'hffff), 1'b0);
    // An address of zero in the low seven bits stops both endpoint groups.
    enqueue(setup_req(usbsrd_pkg::KEY_SET_ADDRESS, 16'h0080, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_DFU_DETACH, 16'h0000, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(usbsrd_pkg::KEY_SET_FILTER, 16'h000f, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req({usbsrd_pkg::KEY_SET_FILTER[7:0], usbsrd_pkg::KEY_SET_FILTER[15:8]},
                      16'h0000, 16'h0000, 16'd0), 1'b0);
    enqueue(setup_req(16'hffff, 16'h0000, 16'h0000, 16'hffff), 1'b0);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      enqueue(random_request(), i == 0 || i == RANDOM_REQUESTS / 2);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (setup_queue.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      fail_count++;
    end
    $display("Checked %0d replies to %0d requests: %0d stalled, %0d bus resets, %0d strings.",
             replies_checked, requests_sent, stall_count, bus_resets, string_replies);
    $display("Output held off %0d times for %0d cycles; input drained %0d times.",
             long_holds, LONG_HOLD, drain_pauses);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/usbsrd_pkg.sv
src/usbsrd_front.sv
src/usbsrd_queue.sv
src/usbsrd_back.sv
src/usb_setup_request_decoder.sv
src/usbsrd_checker.sv
sim/usb_setup_request_decoder_tb.sv
